// ===== rtl/lpwd_pkg.sv =====
// shared types and constants of the length-prefixed word deframer
package lpwd_pkg;

  // deframer phase codes
  localparam logic [1:0] PH_LENGTH = 2'd0;
  localparam logic [1:0] PH_PREFIX = 2'd1;
  localparam logic [1:0] PH_WORD   = 2'd2;
  localparam logic [1:0] PH_FAILED = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // prefix byte patterns
  localparam logic [7:0] SHORT_MASK = 8'h80;
  localparam logic [7:0] PFX1_MASK  = 8'hC0;
  localparam logic [7:0] PFX1_CODE  = 8'h80;
  localparam logic [7:0] PFX2_MASK  = 8'hE0;
  localparam logic [7:0] PFX2_CODE  = 8'hC0;
  localparam logic [7:0] PFX3_MASK  = 8'hF0;
  localparam logic [7:0] PFX3_CODE  = 8'hE0;
  localparam logic [7:0] PFX4_CODE  = 8'hF0;

  localparam int unsigned LEN_W = 32;

  // one result word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// ===== rtl/lpwd_fsm.sv =====
// length prefix decoder and word byte counter
module lpwd_fsm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output logic          res_valid_o,
  output lpwd_pkg::res_t res_o
);
  import lpwd_pkg::*;

  logic [1:0]       phase_q, phase_d;
  logic [2:0]       pfx_left_q, pfx_left_d;
  logic [LEN_W-1:0] len_acc_q, len_acc_d;
  logic [LEN_W-1:0] word_left_q, word_left_d;
  logic [LEN_W-1:0] len_shift;
  logic [2:0]       pfx_dec;
  logic             is_last;

  assign len_shift = {len_acc_q[LEN_W-9:0], byte_i};
  assign pfx_dec   = (pfx_left_q != 3'd0) ? pfx_left_q - 3'd1 : 3'd0;
  assign is_last   = (word_left_q <= LEN_W'(1));

  // next state and result decode for one byte
  always_comb begin
    phase_d     = phase_q;
    pfx_left_d  = pfx_left_q;
    len_acc_d   = len_acc_q;
    word_left_d = word_left_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_DATA, data: 8'h00, last: 1'b0};
    case (phase_q)
      PH_LENGTH: begin
        if (byte_i == 8'h00) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_END;
        end else if ((byte_i & SHORT_MASK) == 8'h00) begin
          phase_d     = PH_WORD;
          word_left_d = LEN_W'(byte_i);
        end else if ((byte_i & PFX1_MASK) == PFX1_CODE) begin
          phase_d    = PH_PREFIX;
          len_acc_d  = LEN_W'(byte_i[5:0]);
          pfx_left_d = 3'd1;
        end else if ((byte_i & PFX2_MASK) == PFX2_CODE) begin
          phase_d    = PH_PREFIX;
          len_acc_d  = LEN_W'(byte_i[4:0]);
          pfx_left_d = 3'd2;
        end else if ((byte_i & PFX3_MASK) == PFX3_CODE) begin
          phase_d    = PH_PREFIX;
          len_acc_d  = LEN_W'(byte_i[3:0]);
          pfx_left_d = 3'd3;
        end else if (byte_i == PFX4_CODE) begin
          phase_d    = PH_PREFIX;
          len_acc_d  = '0;
          pfx_left_d = 3'd4;
        end else begin
          phase_d     = PH_FAILED;
          res_valid_o = 1'b1;
          res_o.kind  = KIND_ERROR;
        end
      end
      PH_PREFIX: begin
        len_acc_d  = len_shift;
        pfx_left_d = pfx_dec;
        if (pfx_dec == 3'd0) begin
          // empty word gives no result
          if (len_shift == '0) begin
            phase_d     = PH_LENGTH;
            word_left_d = '0;
          end else begin
            phase_d     = PH_WORD;
            word_left_d = len_shift;
          end
        end
      end
      PH_WORD: begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_DATA;
        res_o.data  = byte_i;
        res_o.last  = is_last;
        if (is_last) begin
          word_left_d = '0;
          phase_d     = PH_LENGTH;
        end else begin
          word_left_d = word_left_q - LEN_W'(1);
        end
      end
      default: begin
        phase_d = PH_FAILED;
      end
    endcase
  end

  // state registers, updated once per byte taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LENGTH;
      pfx_left_q  <= 3'd0;
      len_acc_q   <= '0;
      word_left_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      pfx_left_q  <= pfx_left_d;
      len_acc_q   <= len_acc_d;
      word_left_q <= word_left_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_failed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FAILED) |=> (phase_q == PH_FAILED))
    else $error("failed phase was left");
  a_prefix_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PREFIX) |-> (pfx_left_q != 3'd0))
    else $error("prefix phase with no length bytes due");
  a_word_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WORD) |-> (word_left_q != '0))
    else $error("word phase with no word bytes due");
  a_no_res_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FAILED) |-> !res_valid_o)
    else $error("result raised after framing error");
`endif

endmodule

// ===== rtl/lpwd_out_buf.sv =====
// two-entry result buffer in front of the output channel
module lpwd_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpwd_pkg::res_t res_i,
  output logic           space_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lpwd_pkg::res_t res_o
);
  import lpwd_pkg::*;

  logic [1:0] count_q, count_d;
  res_t       slot0_q, slot0_d;
  res_t       slot1_q, slot1_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign space_o     = (count_q != 2'd2);
  assign res_o       = slot0_q;

  // slot and count update
  always_comb begin
    count_d = count_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    case (count_q)
      2'd0: begin
        if (push_i) begin
          slot0_d = res_i;
          count_d = 2'd1;
        end
      end
      2'd1: begin
        if (push_i && pop) begin
          slot0_d = res_i;
        end else if (push_i) begin
          slot1_d = res_i;
          count_d = 2'd2;
        end else if (pop) begin
          count_d = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0_d = slot1_q;
          count_d = 2'd1;
        end
      end
      default: begin
        count_d = 2'd0;
      end
    endcase
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

// ===== rtl/length_prefixed_word_deframer_unit.sv =====
// top level of the length-prefixed word deframer
// Usage:
//   Input channel: stream_byte_i with in_valid_i / in_ready_o carries one raw
//   received byte per transfer. Output channel: result_kind_o, word_byte_o and
//   word_end_o with out_valid_o / out_ready_i carry zero or one result per
//   input byte (data byte, end of sentence, or framing error).
//   A byte is taken into an input register, decoded against the prefix state
//   straight from that register, and its result is written into a two-entry
//   output buffer, from which it is offered; decoding waits while the buffer is
//   full. Throughput is one byte per cycle while the buffer has space: the
//   state update is a single pass of short logic, and the output buffer lets
//   input flow while a result waits.
//   Bytes that carry only length information give no result.
//   When the receiver stalls, the buffer fills and in_ready_o drops once it
//   holds two results and a third byte sits in the input register.
//   After a framing error every later byte is taken and dropped until reset.
//   Reset (rst_ni low, asynchronous) empties the input register and output
//   buffer and returns the decoder to waiting for a first length byte.
module length_prefixed_word_deframer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] word_byte_o,
  output logic       word_end_o
);
  import lpwd_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       space;
  logic       step;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  assign step       = in_vld_q && space;
  assign in_ready_o = !in_vld_q || space;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= stream_byte_i;
    end
  end

  // prefix decoder and word counter
  lpwd_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result buffer
  lpwd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign result_kind_o = out_res.kind;
  assign word_byte_o   = out_res.data;
  assign word_end_o    = out_res.last;

endmodule
